// ===== design/ffba_pkg.sv =====
package ffba_pkg;

    // Default sizing of the allocator
    localparam int POOL_BYTES_DEF      = 16384;
    localparam int MAX_BLOCKS_DEF      = 512;
    localparam int HEADER_BYTES_DEF    = 24;
    localparam int MIN_BLOCK_BYTES_DEF = 32;

    // Split only when more than header plus this slack would remain
    localparam int SPLIT_SLACK = 4;
    // Pool size taken after reset, before clamping
    localparam int RESET_POOL  = 16384;
    // Width for size arithmetic and compares
    localparam int CALC_W      = 24;
    // Number of candidate block sizes tried when rounding a request up
    localparam int POW_STEPS   = 17;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_FIT      = 3'd1,
        ST_DOUBLE_FREE = 3'd2,
        ST_UNKNOWN     = 3'd3,
        ST_NULL        = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_PASS = 2'd1,
        S_DONE = 2'd2
    } state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [14:0] request_size;
        logic [13:0] user_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [13:0] result_address;
        logic [14:0] block_size;
    } rsp_t;

    typedef struct packed {
        logic shift;
        logic init;
    } cell_ctl_t;

endpackage

// ===== design/ffba_cell.sv =====
module ffba_cell #(
    parameter int       SW       = $clog2(ffba_pkg::POOL_BYTES_DEF + 1),
    parameter bit       HEAD     = 1'b0,
    parameter int       RST_SIZE = ffba_pkg::RESET_POOL
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ffba_pkg::cell_ctl_t  ctl,
    input  logic                 nxt_valid,
    input  logic                 nxt_free,
    input  logic [SW-1:0]        nxt_start,
    input  logic [SW-1:0]        nxt_size,
    input  logic [SW-1:0]        init_size,
    output logic                 valid,
    output logic                 free,
    output logic [SW-1:0]        start,
    output logic [SW-1:0]        size
);

    logic          valid_reg;
    logic          free_reg;
    logic [SW-1:0] start_reg;
    logic [SW-1:0] size_reg;

    // Hold the entry, take the neighbour's on a shift, reload on init
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= HEAD;
            free_reg  <= 1'b1;
            start_reg <= '0;
            size_reg  <= SW'(RST_SIZE);
        end
        else if (ctl.init)
        begin
            valid_reg <= HEAD;
            free_reg  <= 1'b1;
            start_reg <= '0;
            size_reg  <= init_size;
        end
        else if (ctl.shift)
        begin
            valid_reg <= nxt_valid;
            free_reg  <= nxt_free;
            start_reg <= nxt_start;
            size_reg  <= nxt_size;
        end
    end

    assign valid = valid_reg;
    assign free  = free_reg;
    assign start = start_reg;
    assign size  = size_reg;

endmodule

// ===== design/ffba_ctrl.sv =====
module ffba_ctrl #(
    parameter int POOL_BYTES      = ffba_pkg::POOL_BYTES_DEF,
    parameter int MAX_BLOCKS      = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES    = ffba_pkg::HEADER_BYTES_DEF,
    parameter int MIN_BLOCK_BYTES = ffba_pkg::MIN_BLOCK_BYTES_DEF,
    parameter int SW              = 15
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ffba_pkg::req_t       cmd,
    output logic                 done,
    output ffba_pkg::rsp_t       rsp,
    input  logic                 pool_size_we,
    input  logic [14:0]          pool_size,
    output ffba_pkg::cell_ctl_t  cell_ctl,
    output logic [SW-1:0]        init_size,
    input  logic                 head_valid,
    input  logic                 head_free,
    input  logic [SW-1:0]        head_start,
    input  logic [SW-1:0]        head_size,
    output logic                 tail_valid,
    output logic                 tail_free,
    output logic [SW-1:0]        tail_start,
    output logic [SW-1:0]        tail_size
);

    localparam int CW       = $clog2(MAX_BLOCKS + 1);
    localparam int TW       = $clog2(MAX_BLOCKS + 2);
    localparam int RST_POOL = (ffba_pkg::RESET_POOL > POOL_BYTES) ?
                              POOL_BYTES : ffba_pkg::RESET_POOL;
    localparam int CALC_W   = ffba_pkg::CALC_W;

    typedef struct packed {
        logic          v;
        logic          f;
        logic [SW-1:0] st;
        logic [SW-1:0] sz;
    } ent_t;

    localparam ent_t EMPTY = '{v: 1'b0, f: 1'b0, st: '0, sz: '0};

    ffba_pkg::state_t  state_reg, state_next;
    ffba_pkg::op_t     op_reg, op_next;
    logic [SW-1:0]     pool_reg, pool_next;
    logic [SW-1:0]     good_reg, good_next;
    logic [CALC_W-1:0] tgt_reg, tgt_next;
    logic [TW-1:0]     t_reg, t_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              hit_reg, hit_next;
    logic              mnext_reg, mnext_next;
    logic [2:0]        status_reg, status_next;
    logic [13:0]       raddr_reg, raddr_next;
    logic [14:0]       bsize_reg, bsize_next;
    ent_t              q_reg [3];
    ent_t              q_next [3];
    logic [1:0]        qn_reg, qn_next;

    logic [CALC_W-1:0] pool_clamp;
    logic [CALC_W-1:0] real_sz;
    logic [CALC_W-1:0] good_sz;
    logic              good_found;
    logic [CALC_W-1:0] cand;
    ent_t              e_in;
    ent_t              p0, p1;
    logic [1:0]        pn;
    logic              mod;
    logic [SW-1:0]     add_sz;
    ent_t              q_tail;
    ent_t              s [5];
    logic [2:0]        sn;
    logic              pop;
    ent_t              out_e;
    logic [SW-1:0]     rest;
    logic              split;

    // Clamp a written pool size into the legal range
    always_comb
    begin
        pool_clamp = CALC_W'(pool_size);
        if (pool_clamp < CALC_W'(MIN_BLOCK_BYTES))
            pool_clamp = CALC_W'(MIN_BLOCK_BYTES);
        if (pool_clamp > CALC_W'(POOL_BYTES))
            pool_clamp = CALC_W'(POOL_BYTES);
    end

    // Round header plus payload up to the next allowed block size
    always_comb
    begin
        real_sz    = CALC_W'(cmd.request_size) + CALC_W'(HEADER_BYTES);
        good_sz    = '1;
        good_found = 1'b0;
        cand       = '0;
        for (int k = 0; k < ffba_pkg::POW_STEPS; k++)
        begin
            cand = CALC_W'(MIN_BLOCK_BYTES) << k;
            if (!good_found && cand >= real_sz)
            begin
                good_sz    = cand;
                good_found = 1'b1;
            end
        end
    end

    // Last entry held in the queue, the predecessor of the incoming one
    always_comb
    begin
        q_tail = EMPTY;
        for (int i = 0; i < 3; i++)
        begin
            if (i + 1 == int'(qn_reg))
                q_tail = q_reg[i];
        end
    end

    // Next state, per-entry edit and result bookkeeping
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pool_next   = pool_reg;
        good_next   = good_reg;
        tgt_next    = tgt_reg;
        t_next      = t_reg;
        count_next  = count_reg;
        hit_next    = hit_reg;
        mnext_next  = mnext_reg;
        status_next = status_reg;
        raddr_next  = raddr_reg;
        bsize_next  = bsize_reg;
        cell_ctl    = '{shift: 1'b0, init: 1'b0};
        init_size   = SW'(pool_clamp);
        done        = 1'b0;

        e_in  = '{v: head_valid && (t_reg < TW'(MAX_BLOCKS)), f: head_free,
                  st: head_start, sz: head_size};
        p0    = e_in;
        p1    = EMPTY;
        pn    = 2'd1;
        mod   = 1'b0;
        add_sz = '0;
        rest  = head_size - good_reg;
        split = (CALC_W'(rest) > CALC_W'(HEADER_BYTES + ffba_pkg::SPLIT_SLACK)) &&
                (count_reg < CW'(MAX_BLOCKS));

        case (state_reg)
            ffba_pkg::S_IDLE:
            begin
                if (pool_size_we)
                begin
                    // Reload the table as one free block
                    pool_next     = SW'(pool_clamp);
                    count_next    = CW'(1);
                    cell_ctl.init = 1'b1;
                end
                else if (start)
                begin
                    op_next     = ffba_pkg::op_t'(cmd.opcode);
                    good_next   = SW'(good_sz);
                    tgt_next    = CALC_W'(cmd.user_address) - CALC_W'(HEADER_BYTES);
                    t_next      = '0;
                    hit_next    = 1'b0;
                    mnext_next  = 1'b0;
                    status_next = ffba_pkg::ST_OK;
                    raddr_next  = '0;
                    bsize_next  = '0;
                    state_next  = ffba_pkg::S_PASS;
                    case (ffba_pkg::op_t'(cmd.opcode))
                        ffba_pkg::OP_ALLOC:
                        begin
                            if (real_sz > CALC_W'(pool_reg) || good_sz > CALC_W'(pool_reg))
                            begin
                                status_next = ffba_pkg::ST_NO_FIT;
                                state_next  = ffba_pkg::S_DONE;
                            end
                        end
                        ffba_pkg::OP_FREE, ffba_pkg::OP_QUERY:
                        begin
                            if (cmd.user_address == '0)
                            begin
                                status_next = ffba_pkg::ST_NULL;
                                state_next  = ffba_pkg::S_DONE;
                            end
                            else if (CALC_W'(cmd.user_address) < CALC_W'(HEADER_BYTES))
                            begin
                                status_next = ffba_pkg::ST_UNKNOWN;
                                state_next  = ffba_pkg::S_DONE;
                            end
                        end
                        default:
                        begin
                            status_next = ffba_pkg::ST_NULL;
                            state_next  = ffba_pkg::S_DONE;
                        end
                    endcase
                end
            end

            ffba_pkg::S_PASS:
            begin
                cell_ctl.shift = 1'b1;
                t_next         = t_reg + TW'(1);
                if (!e_in.v)
                begin
                    // Past the table end: keep shifting empties
                    p0 = EMPTY;
                end
                else if (mnext_reg)
                begin
                    // Absorb a free successor into the freed block
                    mnext_next = 1'b0;
                    if (e_in.f)
                    begin
                        mod        = 1'b1;
                        add_sz     = e_in.sz;
                        pn         = 2'd0;
                        count_next = count_reg - CW'(1);
                    end
                end
                else if (!hit_reg)
                begin
                    case (op_reg)
                        ffba_pkg::OP_ALLOC:
                        begin
                            if (e_in.f && head_size >= good_reg)
                            begin
                                hit_next   = 1'b1;
                                raddr_next = 14'(CALC_W'(head_start) + CALC_W'(HEADER_BYTES));
                                p0.f       = 1'b0;
                                if (split)
                                begin
                                    p0.sz      = good_reg;
                                    p1         = '{v: 1'b1, f: 1'b1,
                                                   st: head_start + good_reg, sz: rest};
                                    pn         = 2'd2;
                                    count_next = count_reg + CW'(1);
                                    bsize_next = 15'(CALC_W'(good_reg));
                                end
                                else
                                begin
                                    bsize_next = 15'(CALC_W'(head_size));
                                end
                            end
                        end
                        ffba_pkg::OP_FREE:
                        begin
                            if (CALC_W'(head_start) == tgt_reg)
                            begin
                                hit_next = 1'b1;
                                if (e_in.f)
                                begin
                                    status_next = ffba_pkg::ST_DOUBLE_FREE;
                                end
                                else
                                begin
                                    mnext_next = 1'b1;
                                    if (qn_reg != 2'd0 && q_tail.v && q_tail.f)
                                    begin
                                        // Fold into the free predecessor
                                        mod        = 1'b1;
                                        add_sz     = e_in.sz;
                                        pn         = 2'd0;
                                        count_next = count_reg - CW'(1);
                                    end
                                    else
                                    begin
                                        p0.f = 1'b1;
                                    end
                                end
                            end
                        end
                        ffba_pkg::OP_QUERY:
                        begin
                            if (CALC_W'(head_start) == tgt_reg)
                            begin
                                hit_next   = 1'b1;
                                bsize_next = 15'(CALC_W'(head_size));
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (t_reg == TW'(MAX_BLOCKS + 1))
                begin
                    state_next = ffba_pkg::S_DONE;
                    if (!hit_next)
                        status_next = (op_reg == ffba_pkg::OP_ALLOC) ?
                                      ffba_pkg::ST_NO_FIT : ffba_pkg::ST_UNKNOWN;
                end
            end

            ffba_pkg::S_DONE:
            begin
                done       = 1'b1;
                state_next = ffba_pkg::S_IDLE;
            end

            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    // Queue held entries plus this cycle's pushes, then emit the oldest
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            s[i] = EMPTY;
            if (i < int'(qn_reg) && i < 3)
            begin
                s[i] = q_reg[i];
                if (mod && i + 1 == int'(qn_reg))
                    s[i].sz = q_reg[i].sz + add_sz;
            end
            else if (i == int'(qn_reg) && pn != 2'd0)
            begin
                s[i] = p0;
            end
            else if (i == int'(qn_reg) + 1 && pn == 2'd2)
            begin
                s[i] = p1;
            end
        end
        sn    = 3'(qn_reg) + 3'(pn);
        pop   = (state_reg == ffba_pkg::S_PASS) && (t_reg >= TW'(2)) && (sn != 3'd0);
        out_e = pop ? s[0] : EMPTY;
        for (int j = 0; j < 3; j++)
            q_next[j] = pop ? s[j + 1] : s[j];
        qn_next = pop ? 2'(sn - 3'd1) : 2'(sn);
        if (state_reg != ffba_pkg::S_PASS)
            qn_next = 2'd0;
    end

    assign tail_valid = out_e.v;
    assign tail_free  = out_e.f;
    assign tail_start = out_e.st;
    assign tail_size  = out_e.sz;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffba_pkg::S_IDLE;
            pool_reg  <= SW'(RST_POOL);
            count_reg <= CW'(1);
            t_reg     <= '0;
            hit_reg   <= 1'b0;
            mnext_reg <= 1'b0;
            qn_reg    <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pool_reg  <= pool_next;
            count_reg <= count_next;
            t_reg     <= t_next;
            hit_reg   <= hit_next;
            mnext_reg <= mnext_next;
            qn_reg    <= qn_next;
        end
    end

    // Request and result words, queue payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        good_reg   <= good_next;
        tgt_reg    <= tgt_next;
        status_reg <= status_next;
        raddr_reg  <= raddr_next;
        bsize_reg  <= bsize_next;
        for (int j = 0; j < 3; j++)
            q_reg[j] <= q_next[j];
    end

    assign busy = (state_reg != ffba_pkg::S_IDLE);
    assign rsp  = '{status: status_reg, result_address: raddr_reg, block_size: bsize_reg};

endmodule

// ===== design/first_fit_block_allocator_top.sv =====
// First-fit block allocator with coalescing.
// Command channel: a request word (cmd) is taken at a clock edge where
// start is high and busy is low. busy stays high until the result is out.
// Result channel: done pulses for one cycle with the result word on rsp;
// the receiver cannot stall it and must take it in that cycle.
// Configuration: pool_size_we with pool_size, written while idle, clamps
// the size and reloads the table as a single free block.
// Table walk: an allocate, free or query that must look at the table
// raises done once the whole table has circulated through the row of
// cells past the controller, one entry per cycle; busy drops after the
// done cycle, so a new request is taken only once the last is through.
// Requests rejected up front (too large, null address, address below
// the header, unused opcode) raise done in the cycle after acceptance.
// Reset: one free block of the default pool size, nothing pending.
module first_fit_block_allocator_top #(
    parameter int POOL_BYTES      = ffba_pkg::POOL_BYTES_DEF,
    parameter int MAX_BLOCKS      = ffba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES    = ffba_pkg::HEADER_BYTES_DEF,
    parameter int MIN_BLOCK_BYTES = ffba_pkg::MIN_BLOCK_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ffba_pkg::req_t  cmd,
    output logic            done,
    output ffba_pkg::rsp_t  rsp,
    input  logic            pool_size_we,
    input  logic [14:0]     pool_size
);

    localparam int SW       = $clog2(POOL_BYTES + 1);
    localparam int RST_POOL = (ffba_pkg::RESET_POOL > POOL_BYTES) ?
                              POOL_BYTES : ffba_pkg::RESET_POOL;

    ffba_pkg::cell_ctl_t cell_ctl;
    logic [SW-1:0]       init_size;
    logic                cv  [MAX_BLOCKS];
    logic                cf  [MAX_BLOCKS];
    logic [SW-1:0]       cst [MAX_BLOCKS];
    logic [SW-1:0]       csz [MAX_BLOCKS];
    logic                tail_valid;
    logic                tail_free;
    logic [SW-1:0]       tail_start;
    logic [SW-1:0]       tail_size;

    ffba_ctrl #(
        .POOL_BYTES      (POOL_BYTES),
        .MAX_BLOCKS      (MAX_BLOCKS),
        .HEADER_BYTES    (HEADER_BYTES),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .SW              (SW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .done         (done),
        .rsp          (rsp),
        .pool_size_we (pool_size_we),
        .pool_size    (pool_size),
        .cell_ctl     (cell_ctl),
        .init_size    (init_size),
        .head_valid   (cv[0]),
        .head_free    (cf[0]),
        .head_start   (cst[0]),
        .head_size    (csz[0]),
        .tail_valid   (tail_valid),
        .tail_free    (tail_free),
        .tail_start   (tail_start),
        .tail_size    (tail_size)
    );

    // Row of table cells; entries move one place toward the head per shift
    for (genvar i = 0; i < MAX_BLOCKS; i++)
    begin : g_cell
        if (i == MAX_BLOCKS - 1)
        begin : g_last
            ffba_cell #(
                .SW       (SW),
                .HEAD     ((i == 0) ? 1'b1 : 1'b0),
                .RST_SIZE (RST_POOL)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl),
                .nxt_valid (tail_valid),
                .nxt_free  (tail_free),
                .nxt_start (tail_start),
                .nxt_size  (tail_size),
                .init_size ((i == 0) ? init_size : SW'(0)),
                .valid     (cv[i]),
                .free      (cf[i]),
                .start     (cst[i]),
                .size      (csz[i])
            );
        end
        else
        begin : g_mid
            ffba_cell #(
                .SW       (SW),
                .HEAD     ((i == 0) ? 1'b1 : 1'b0),
                .RST_SIZE (RST_POOL)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (cell_ctl),
                .nxt_valid (cv[i + 1]),
                .nxt_free  (cf[i + 1]),
                .nxt_start (cst[i + 1]),
                .nxt_size  (csz[i + 1]),
                .init_size ((i == 0) ? init_size : SW'(0)),
                .valid     (cv[i]),
                .free      (cf[i]),
                .start     (cst[i]),
                .size      (csz[i])
            );
        end
    end

endmodule

// ===== tb/first_fit_block_allocator_top_tb.sv =====
module first_fit_block_allocator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL_MAX   = 16384;
    localparam int TABLE_MAX  = 512;
    localparam int HDR        = 24;
    localparam int MIN_BLOCK  = 32;
    localparam int SLACK      = 4;
    localparam int DRAIN_WAIT = TABLE_MAX + 16;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    ffba_pkg::req_t  cmd;
    logic            done;
    ffba_pkg::rsp_t  rsp;
    logic            pool_size_we;
    logic [14:0]     pool_size;

    first_fit_block_allocator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .done         (done),
        .rsp          (rsp),
        .pool_size_we (pool_size_we),
        .pool_size    (pool_size)
    );

    // Shadow allocator state
    int  shadow_pool;
    int  blk_base [TABLE_MAX];
    int  blk_len  [TABLE_MAX];
    bit  blk_idle [TABLE_MAX];
    int  blk_count;

    ffba_pkg::rsp_t pending_rsp [$];
    int             live_addrs  [$];
    int             mismatches;

    typedef struct {
        ffba_pkg::op_t  op;
        int             req_size;
        int             addr;
        bit             typed;
        ffba_pkg::rsp_t want;
    } stim_row_t;

    stim_row_t stim_rows [$];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Reload the shadow table as one free block
    function automatic void shadow_reload(input int v);
        int i;
        if (v < MIN_BLOCK)
            v = MIN_BLOCK;
        if (v > POOL_MAX)
            v = POOL_MAX;
        shadow_pool = v;
        for (i = 0; i < TABLE_MAX; i++)
        begin
            blk_base[i] = 0;
            blk_len[i]  = 0;
            blk_idle[i] = 0;
        end
        blk_len[0]  = v;
        blk_idle[0] = 1;
        blk_count   = 1;
    endfunction

    function automatic void drop_entry(input int k);
        int j;
        for (j = k; j < blk_count - 1; j++)
        begin
            blk_base[j] = blk_base[j + 1];
            blk_len[j]  = blk_len[j + 1];
            blk_idle[j] = blk_idle[j + 1];
        end
        blk_count--;
    endfunction

    function automatic int lookup_block(input int a);
        int j;
        if (a < HDR)
            return -1;
        for (j = 0; j < blk_count; j++)
            if (blk_base[j] == a - HDR)
                return j;
        return -1;
    endfunction

    // Work out the response to one request and advance the shadow table
    function automatic ffba_pkg::rsp_t allocator_step(input ffba_pkg::req_t c);
        ffba_pkg::rsp_t r;
        int   want_len, good, k, j, rest;
        r = '0;
        case (ffba_pkg::op_t'(c.opcode))
            ffba_pkg::OP_ALLOC:
            begin
                want_len = int'(c.request_size) + HDR;
                good = MIN_BLOCK;
                while (good < want_len)
                    good = good << 1;
                if (want_len > shadow_pool || good > shadow_pool)
                    r.status = ffba_pkg::ST_NO_FIT;
                else
                begin
                    k = -1;
                    for (j = 0; j < blk_count && k < 0; j++)
                        if (blk_idle[j] && blk_len[j] >= good)
                            k = j;
                    if (k < 0)
                        r.status = ffba_pkg::ST_NO_FIT;
                    else
                    begin
                        rest = blk_len[k] - good;
                        if (rest > HDR + SLACK && blk_count < TABLE_MAX)
                        begin
                            for (j = blk_count; j > k + 1; j--)
                            begin
                                blk_base[j] = blk_base[j - 1];
                                blk_len[j]  = blk_len[j - 1];
                                blk_idle[j] = blk_idle[j - 1];
                            end
                            blk_base[k + 1] = blk_base[k] + good;
                            blk_len[k + 1]  = rest;
                            blk_idle[k + 1] = 1;
                            blk_len[k]      = good;
                            blk_count++;
                        end
                        blk_idle[k]      = 0;
                        r.status         = ffba_pkg::ST_OK;
                        r.result_address = 14'(blk_base[k] + HDR);
                        r.block_size     = 15'(blk_len[k]);
                    end
                end
            end
            ffba_pkg::OP_FREE:
            begin
                k = lookup_block(int'(c.user_address));
                if (c.user_address == 0)
                    r.status = ffba_pkg::ST_NULL;
                else if (k < 0)
                    r.status = ffba_pkg::ST_UNKNOWN;
                else if (blk_idle[k])
                    r.status = ffba_pkg::ST_DOUBLE_FREE;
                else
                begin
                    r.status = ffba_pkg::ST_OK;
                    blk_idle[k] = 1;
                    if (k + 1 < blk_count && blk_idle[k + 1])
                    begin
                        blk_len[k] += blk_len[k + 1];
                        drop_entry(k + 1);
                    end
                    if (k > 0 && blk_idle[k - 1])
                    begin
                        blk_len[k - 1] += blk_len[k];
                        drop_entry(k);
                    end
                end
            end
            ffba_pkg::OP_QUERY:
            begin
                k = lookup_block(int'(c.user_address));
                if (c.user_address == 0)
                    r.status = ffba_pkg::ST_NULL;
                else if (k < 0)
                    r.status = ffba_pkg::ST_UNKNOWN;
                else
                begin
                    r.status     = ffba_pkg::ST_OK;
                    r.block_size = 15'(blk_len[k]);
                end
            end
            default:
                r.status = ffba_pkg::ST_NULL;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Check each response word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("response with none outstanding", int'(rsp.status), -1);
            else
            begin
                ffba_pkg::rsp_t w;
                w = pending_rsp.pop_front();
                if (rsp.status !== w.status)
                    report_mismatch("status", int'(rsp.status), int'(w.status));
                if (rsp.result_address !== w.result_address)
                    report_mismatch("result_address", int'(rsp.result_address),
                                    int'(w.result_address));
                if (rsp.block_size !== w.block_size)
                    report_mismatch("block_size", int'(rsp.block_size), int'(w.block_size));
            end
        end
    end

    // Record the expectation for an accepted request and track live blocks
    task automatic note_accepted(input ffba_pkg::req_t c, input bit typed,
                                 input ffba_pkg::rsp_t want);
        ffba_pkg::rsp_t r;
        int   idx [$];
        r = allocator_step(c);
        pending_rsp.push_back(typed ? want : r);
        if (r.status == ffba_pkg::ST_OK && ffba_pkg::op_t'(c.opcode) == ffba_pkg::OP_ALLOC)
            live_addrs.push_back(int'(r.result_address));
        if (r.status == ffba_pkg::ST_OK && ffba_pkg::op_t'(c.opcode) == ffba_pkg::OP_FREE)
        begin
            idx = live_addrs.find_first_index(x) with (x == int'(c.user_address));
            if (idx.size() > 0)
                live_addrs.delete(idx[0]);
        end
    endtask

    // Present one word and hold it until the block takes it
    task automatic send_word(input ffba_pkg::req_t c, input bit typed,
                             input ffba_pkg::rsp_t want);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        note_accepted(c, typed, want);
    endtask

    // Wait for all words out and the block idle, then write the pool size
    task automatic write_pool(input int v);
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        pool_size_we <= 1'b1;
        pool_size    <= 15'(v);
        @(posedge clk);
        pool_size_we <= 1'b0;
        shadow_reload(v);
        live_addrs.delete();
    endtask

    function automatic int pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75 && live_addrs.size() > 0)
            return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        if (r < 85)
            return 0;
        return $urandom_range(0, 16383);
    endfunction

    function automatic ffba_pkg::req_t random_word(input bit heavy);
        ffba_pkg::req_t c;
        int   r, s;
        c.request_size = 15'($urandom_range(0, 32767));
        c.user_address = 14'($urandom_range(0, 16383));
        r = $urandom_range(0, 99);
        if (r < (heavy ? 80 : 55))
        begin
            c.opcode = ffba_pkg::OP_ALLOC;
            s = $urandom_range(0, 99);
            if (s < 70)
                c.request_size = 15'($urandom_range(0, 40));
            else if (s < 90)
                c.request_size = 15'($urandom_range(0, 1000));
            else if (s < 98)
                c.request_size = 15'($urandom_range(0, shadow_pool));
        end
        else if (r < (heavy ? 95 : 85))
        begin
            c.opcode       = ffba_pkg::OP_FREE;
            c.user_address = 14'(pick_addr());
        end
        else if (r < 98)
        begin
            c.opcode       = ffba_pkg::OP_QUERY;
            c.user_address = 14'(pick_addr());
        end
        else
            c.opcode = ffba_pkg::OP_NONE;
        return c;
    endfunction

    function automatic void add_row(input ffba_pkg::op_t op, input int rs, input int a,
                                    input bit typed, input ffba_pkg::status_t st,
                                    input int ra, input int bs);
        stim_row_t row;
        row.op   = op;
        row.req_size = rs;
        row.addr = a;
        row.typed = typed;
        row.want.status         = st;
        row.want.result_address = 14'(ra);
        row.want.block_size     = 15'(bs);
        stim_rows.push_back(row);
    endfunction

    initial
    begin
        ffba_pkg::req_t c;
        ffba_pkg::rsp_t none;
        int   ph, n;
        int   phase_pool [5];
        int   phase_len  [5];

        phase_pool   = '{16384, 0, 777, 32767, 2048};
        phase_len    = '{560, 40, 160, 200, 190};
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        pool_size_we = 1'b0;
        pool_size    = '0;
        mismatches   = 0;
        none         = '0;
        shadow_reload(16384);

        // Directed rows after reset
        add_row(ffba_pkg::OP_QUERY, 0, 0, 1, ffba_pkg::ST_NULL, 0, 0);
        add_row(ffba_pkg::OP_FREE, 0, 0, 1, ffba_pkg::ST_NULL, 0, 0);
        add_row(ffba_pkg::OP_NONE, 32767, 16383, 1, ffba_pkg::ST_NULL, 0, 0);
        add_row(ffba_pkg::OP_ALLOC, 32767, 0, 1, ffba_pkg::ST_NO_FIT, 0, 0);
        add_row(ffba_pkg::OP_ALLOC, 16384, 0, 1, ffba_pkg::ST_NO_FIT, 0, 0);
        add_row(ffba_pkg::OP_ALLOC, 16360, 0, 1, ffba_pkg::ST_OK, 24, 16384);
        add_row(ffba_pkg::OP_ALLOC, 0, 0, 1, ffba_pkg::ST_NO_FIT, 0, 0);
        add_row(ffba_pkg::OP_QUERY, 0, 24, 1, ffba_pkg::ST_OK, 0, 16384);
        add_row(ffba_pkg::OP_FREE, 0, 24, 1, ffba_pkg::ST_OK, 0, 0);
        add_row(ffba_pkg::OP_FREE, 0, 24, 1, ffba_pkg::ST_DOUBLE_FREE, 0, 0);
        add_row(ffba_pkg::OP_QUERY, 0, 24, 1, ffba_pkg::ST_OK, 0, 16384);
        add_row(ffba_pkg::OP_QUERY, 0, 10, 1, ffba_pkg::ST_UNKNOWN, 0, 0);
        add_row(ffba_pkg::OP_FREE, 0, 23, 1, ffba_pkg::ST_UNKNOWN, 0, 0);
        add_row(ffba_pkg::OP_FREE, 0, 5000, 1, ffba_pkg::ST_UNKNOWN, 0, 0);
        add_row(ffba_pkg::OP_ALLOC, 0, 0, 1, ffba_pkg::ST_OK, 24, 32);
        add_row(ffba_pkg::OP_ALLOC, 8, 0, 1, ffba_pkg::ST_OK, 56, 32);
        add_row(ffba_pkg::OP_ALLOC, 100, 0, 0, ffba_pkg::ST_OK, 0, 0);
        add_row(ffba_pkg::OP_FREE, 0, 56, 0, ffba_pkg::ST_OK, 0, 0);
        add_row(ffba_pkg::OP_FREE, 0, 24, 0, ffba_pkg::ST_OK, 0, 0);
        add_row(ffba_pkg::OP_ALLOC, 40, 0, 0, ffba_pkg::ST_OK, 0, 0);
        add_row(ffba_pkg::OP_FREE, 0, 88, 0, ffba_pkg::ST_OK, 0, 0);
        add_row(ffba_pkg::OP_QUERY, 0, 16383, 1, ffba_pkg::ST_UNKNOWN, 0, 0);
        add_row(ffba_pkg::OP_QUERY, 0, 88, 0, ffba_pkg::ST_OK, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        foreach (stim_rows[i])
        begin
            c.opcode       = stim_rows[i].op;
            c.request_size = 15'(stim_rows[i].req_size);
            c.user_address = 14'(stim_rows[i].addr);
            send_word(c, stim_rows[i].typed, stim_rows[i].want);
        end

        // Random phases, each with its own pool size
        for (ph = 0; ph < 5; ph++)
        begin
            write_pool(phase_pool[ph]);
            for (n = 0; n < phase_len[ph]; n++)
                send_word(random_word(ph == 0), 1'b0, none);
        end

        // Drain and give the block time to settle
        start <= 1'b0;
        @(posedge clk);
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
design/ffba_pkg.sv
design/ffba_cell.sv
design/ffba_ctrl.sv
design/first_fit_block_allocator_top.sv
tb/first_fit_block_allocator_top_tb.sv
